@@ hdl/asat_pkg.sv @@
// shared constants, types, exp tables and rounding helpers for the saturation mixer
package asat_pkg;

  // sample format: signed, one integer bit
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = SAMPLE_BITS - 1;

  // exp table depth, a power of two
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);

  // stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  // register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_REG_W  = 16;

  // gain constants, Q15
  localparam int ONE_Q15 = 32768;
  localparam int K02_Q15 = 6554;

  // shaping constants, Q32 before conversion
  localparam longint K04_Q32 = longint'(1717986918);
  localparam longint K03_Q32 = longint'(1288490189);
  localparam longint K01_Q32 = longint'(429496730);

  // Q32 to sample fraction, rounded
  function automatic longint q32_to_frac(input longint c);
    return (c + (longint'(1) <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  endfunction

  // knee threshold 0.4 and harmonic weights
  localparam longint KNEE_T = q32_to_frac(K04_Q32);
  localparam longint COEF_03 = q32_to_frac(K03_Q32);
  localparam longint COEF_01 = q32_to_frac(K01_Q32);

  // step ratio exp(-16 / depth) in Q30 from a series up to the 12th-order term
  localparam longint EXP_ONE  = longint'(1) <<< 30;
  localparam longint EXP_STEP = (longint'(16) <<< 30) / EXP_TABLE_DEPTH;
  localparam longint EXP_T1   = ((EXP_ONE * EXP_STEP) >>> 30) / 1;
  localparam longint EXP_T2   = ((EXP_T1 * EXP_STEP) >>> 30) / 2;
  localparam longint EXP_T3   = ((EXP_T2 * EXP_STEP) >>> 30) / 3;
  localparam longint EXP_T4   = ((EXP_T3 * EXP_STEP) >>> 30) / 4;
  localparam longint EXP_T5   = ((EXP_T4 * EXP_STEP) >>> 30) / 5;
  localparam longint EXP_T6   = ((EXP_T5 * EXP_STEP) >>> 30) / 6;
  localparam longint EXP_T7   = ((EXP_T6 * EXP_STEP) >>> 30) / 7;
  localparam longint EXP_T8   = ((EXP_T7 * EXP_STEP) >>> 30) / 8;
  localparam longint EXP_T9   = ((EXP_T8 * EXP_STEP) >>> 30) / 9;
  localparam longint EXP_T10  = ((EXP_T9 * EXP_STEP) >>> 30) / 10;
  localparam longint EXP_T11  = ((EXP_T10 * EXP_STEP) >>> 30) / 11;
  localparam longint EXP_T12  = ((EXP_T11 * EXP_STEP) >>> 30) / 12;
  localparam longint EXP_RATIO = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5
                               + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10 - EXP_T11
                               + EXP_T12;

  typedef longint exp_full_t [EXP_TABLE_DEPTH + 1];
  typedef logic [30:0] exp_base_t [EXP_TABLE_DEPTH];
  typedef logic [29:0] exp_diff_t [EXP_TABLE_DEPTH];

  // exp(-16 i / depth) in Q30, each entry the previous one times the step ratio
  function automatic exp_full_t build_exp_full();
    exp_full_t e;
    e[0] = EXP_ONE;
    for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
      e[i] = (e[i - 1] * EXP_RATIO + (longint'(1) <<< 29)) >>> 30;
    end
    return e;
  endfunction

  // table entry at each index
  function automatic exp_base_t build_exp_base();
    exp_full_t e;
    exp_base_t b;
    e = build_exp_full();
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      b[i] = 31'(e[i]);
    end
    return b;
  endfunction

  // drop from each entry to the next
  function automatic exp_diff_t build_exp_diff();
    exp_full_t e;
    exp_diff_t d;
    e = build_exp_full();
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      d[i] = 30'(e[i] - e[i + 1]);
    end
    return d;
  endfunction

  localparam exp_base_t EXP_BASE = build_exp_base();
  localparam exp_diff_t EXP_DIFF = build_exp_diff();

  // signed shift right by n, rounding half away from zero
  function automatic logic signed [63:0] rnd_s(input logic signed [63:0] v, input int n);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (n - 1));
    if (v[63]) begin
      t = t - 64'sd1;
    end
    return t >>> n;
  endfunction

endpackage

@@ hdl/asymmetric_saturation_mix.sv @@
// asymmetric saturation mixer: shaping pipeline, cross-fade, register port and output skid
//
//  channel  | direction | handshake                 | content
//  s_*      | in        | s_tvalid / s_tready       | s_tdata: dry_sample, filtered_sample
//  m_*      | out       | m_tvalid / m_tready       | m_tdata: out_sample
//  apb      | in        | psel, penable, pwrite     | drive_amount at 0x0, mix_amount at 0x4
//
// One item per clock while the skid register is free. An item taken passes through the
// 25 register stages of the shaper and mixer and then the output register to m_tvalid.
// Synchronous reset clears the valid bits, the output and skid valid flags and both gain
// registers; after reset the block passes the dry sample through.
// A stalled output keeps its item; the next item lands in the skid register and the
// whole pipeline holds while the skid register is full, so s_tready drops only then.
module asymmetric_saturation_mix
  import asat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // dry_sample, filtered_sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_sample
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int FR    = FRAC_BITS;
  localparam int XW    = SB + 6;
  localparam int ARGW  = XW + 2;
  localparam int POSW  = ARGW + EXP_IDX_BITS;
  localparam int KPW   = SB + 31;
  localparam int NST   = 25;
  localparam int YOW   = SB + 5;

  localparam logic REG_DRIVE = 1'b0;
  localparam logic REG_MIX   = 1'b1;

  localparam logic [SB-1:0]        T_U     = SB'(KNEE_T);
  localparam logic signed [XW-1:0] T_X     = XW'(KNEE_T);
  localparam logic signed [XW-1:0] T_XN    = XW'(-KNEE_T);
  localparam logic signed [SB-1:0] C04     = SB'(KNEE_T);
  localparam logic signed [SB-1:0] C03     = SB'(COEF_03);
  localparam logic signed [SB-1:0] C01     = SB'(COEF_01);
  localparam logic signed [YOW-1:0] SAT_HI = YOW'((longint'(1) <<< FR) - 1);
  localparam logic signed [YOW-1:0] SAT_LO = YOW'(-(longint'(1) <<< FR));

  // configuration registers and values derived from them
  logic [CFG_REG_W-1:0] drive_amount;
  logic [CFG_REG_W-1:0] mix_amount;
  logic signed [16:0]   drv_s;
  logic signed [21:0]   gain_pre;
  logic signed [16:0]   gain_post;
  logic                 drv_zero;
  logic signed [16:0]   mix_s;
  logic signed [16:0]   mix_inv;

  logic [15:0]        dsat;
  logic [15:0]        msat;
  logic [31:0]        dd;
  logic [37:0]        dd40;
  logic [29:0]        pr;
  logic [21:0]        gain_pre_next;
  logic [16:0]        gain_post_next;

  // pipeline control
  logic [NST-1:0] vld;
  logic           en;

  // stage registers
  logic signed [SB-1:0]      dry_d [0:22];
  logic signed [SB-1:0]      flt_d [0:21];
  logic signed [SB+21:0]     xp1;
  logic signed [XW-1:0]      x_d [2:8];
  logic                      pos_d [3:8];
  logic                      over_d [3:8];
  logic [XW-1:0]             abs3;
  logic                      big_d [4:6];
  logic [EXP_IDX_BITS-1:0]   idx4;
  logic [15:0]               rem_d [4:5];
  logic [30:0]               base_d [5:6];
  logic [29:0]               dif5;
  logic [45:0]               dr6;
  logic [30:0]               om7;
  logic [KPW-1:0]            kp8;
  logic signed [SB-1:0]      y_d [9:19];
  logic signed [2*SB-1:0]    y2p10;
  logic signed [SB-1:0]      y2_11;
  logic signed [2*SB-1:0]    y3p12;
  logic signed [2*SB-1:0]    y4p12;
  logic signed [2*SB-1:0]    a2p12;
  logic signed [SB-1:0]      y3_13;
  logic signed [SB-1:0]      y4_13;
  logic signed [SB-1:0]      a2_d [13:15];
  logic signed [2*SB-1:0]    a3p14;
  logic signed [2*SB-1:0]    a4p14;
  logic signed [SB-1:0]      a3_15;
  logic signed [SB-1:0]      a4_15;
  logic signed [SB:0]        s23_16;
  logic signed [SB+16:0]     b1p16;
  logic signed [SB+17:0]     h1p17;
  logic signed [SB-1:0]      b17;
  logic signed [SB:0]        h1_d [18:19];
  logic signed [SB+16:0]     h2p18;
  logic signed [SB-1:0]      h2_19;
  logic signed [SB+1:0]      sum20;
  logic signed [SB+18:0]     wp21;
  logic signed [SB+1:0]      wet22;
  logic signed [SB+16:0]     mp1_23;
  logic signed [SB+18:0]     mp2_23;
  logic signed [SB+19:0]     tot24;

  // combinational stage inputs
  logic signed [XW-1:0]      x_rnd;
  logic [XW-1:0]             dif4;
  logic [ARGW-1:0]           arg4;
  logic [POSW-1:0]           pos4;
  logic [KPW-1:0]            kp_rnd;
  logic [SB-1:0]             mag9;
  logic signed [SB-1:0]      y9;
  logic signed [SB+1:0]      wet_shaped;
  logic signed [YOW-1:0]     y_out;
  logic signed [SB-1:0]      out_next;

  // output and skid registers
  logic                 out_valid;
  logic signed [SB-1:0] out_sample;
  logic                 skid_valid;
  logic signed [SB-1:0] skid_sample;
  logic                 push;

  // register port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[CFG_ADDR_W-1])
      REG_DRIVE: prdata = {{(CFG_DATA_W - CFG_REG_W){1'b0}}, drive_amount};
      REG_MIX:   prdata = {{(CFG_DATA_W - CFG_REG_W){1'b0}}, mix_amount};
      default:   prdata = '0;
    endcase
  end

  // clamp registers to 1.0 and work out the gains
  always_comb begin
    dsat = (drive_amount > 16'(ONE_Q15)) ? 16'(ONE_Q15) : drive_amount;
    msat = (mix_amount > 16'(ONE_Q15)) ? 16'(ONE_Q15) : mix_amount;
    dd   = 32'(dsat) * 32'(dsat);
    dd40 = ({6'b0, dd} << 5) + ({6'b0, dd} << 3);
    gain_pre_next = 22'((dd40 + 38'd16384) >> 15) + 22'(ONE_Q15);
    pr = 30'(dsat) * 30'(K02_Q15);
    gain_post_next = 17'(ONE_Q15) - 17'((pr + 30'd16384) >> 15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_amount <= '0;
      mix_amount   <= '0;
      drv_s        <= '0;
      gain_pre     <= 22'(ONE_Q15);
      gain_post    <= 17'(ONE_Q15);
      drv_zero     <= 1'b1;
      mix_s        <= '0;
      mix_inv      <= 17'(ONE_Q15);
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[CFG_ADDR_W-1])
          REG_DRIVE: drive_amount <= pwdata[CFG_REG_W-1:0];
          REG_MIX:   mix_amount   <= pwdata[CFG_REG_W-1:0];
          default:   drive_amount <= drive_amount;
        endcase
      end
      drv_s     <= {1'b0, dsat};
      gain_pre  <= gain_pre_next;
      gain_post <= gain_post_next;
      drv_zero  <= (drive_amount == '0);
      mix_s     <= {1'b0, msat};
      mix_inv   <= 17'(ONE_Q15) - {1'b0, msat};
    end
  end

  // pipeline advances whenever the skid register is free
  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // knee and table lookup terms
  always_comb begin
    x_rnd = XW'(rnd_s(64'(xp1), 15));
    dif4  = abs3 - XW'(KNEE_T);
    arg4  = pos_d[3] ? {dif4, 2'b00} : {1'b0, dif4, 1'b0};
    pos4  = {arg4, {EXP_IDX_BITS{1'b0}}};
  end

  // knee magnitude and shaped sample
  always_comb begin
    kp_rnd = kp8 + (KPW'(1) << 29);
    mag9   = T_U + kp_rnd[30 +: SB];
    if (over_d[8]) begin
      y9 = pos_d[8] ? $signed(mag9) : $signed(SB'(0) - mag9);
    end else begin
      y9 = x_d[8][SB-1:0];
    end
  end

  // wet value and final mix rounding
  always_comb begin
    wet_shaped = (SB + 2)'(rnd_s(64'(wp21), 15));
    y_out      = YOW'(rnd_s(64'(tot24), 15));
    if (y_out > SAT_HI) begin
      out_next = SAT_HI[SB-1:0];
    end else if (y_out < SAT_LO) begin
      out_next = SAT_LO[SB-1:0];
    end else begin
      out_next = y_out[SB-1:0];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // input, pre-gain
      dry_d[0] <= s_tdata[SB-1:0];
      flt_d[0] <= s_tdata[2*SB-1:SB];
      for (int i = 1; i <= 22; i++) begin
        dry_d[i] <= dry_d[i - 1];
      end
      for (int i = 1; i <= 21; i++) begin
        flt_d[i] <= flt_d[i - 1];
      end
      xp1 <= flt_d[0] * gain_pre;

      // rounding, knee test, argument and table position
      x_d[2] <= x_rnd;
      for (int i = 3; i <= 8; i++) begin
        x_d[i] <= x_d[i - 1];
      end
      pos_d[3]  <= !x_d[2][XW-1] && (x_d[2] != '0);
      over_d[3] <= (x_d[2] > T_X) || (x_d[2] < T_XN);
      abs3      <= x_d[2][XW-1] ? XW'(-x_d[2]) : x_d[2];
      for (int i = 4; i <= 8; i++) begin
        pos_d[i]  <= pos_d[i - 1];
        over_d[i] <= over_d[i - 1];
      end
      big_d[4] <= |arg4[ARGW-1:FR+4];
      big_d[5] <= big_d[4];
      big_d[6] <= big_d[5];
      idx4     <= pos4[FR+4 +: EXP_IDX_BITS];
      rem_d[4] <= pos4[FR-12 +: 16];
      rem_d[5] <= rem_d[4];

      // table read, interpolation, knee magnitude
      base_d[5] <= EXP_BASE[idx4];
      dif5      <= EXP_DIFF[idx4];
      base_d[6] <= base_d[5];
      dr6       <= 46'(dif5) * 46'(rem_d[5]);
      om7       <= big_d[6] ? 31'h4000_0000 :
                   31'(32'h4000_0000 - 32'(base_d[6]) + 32'(dr6[45:16]));
      kp8       <= KPW'(T_U) * KPW'(om7);

      // shaped sample and its powers
      y_d[9] <= y9;
      for (int i = 10; i <= 19; i++) begin
        y_d[i] <= y_d[i - 1];
      end
      y2p10 <= y_d[9] * y_d[9];
      y2_11 <= SB'(rnd_s(64'(y2p10), FR));
      y3p12 <= y2_11 * y_d[11];
      y4p12 <= y2_11 * y2_11;
      a2p12 <= y2_11 * C04;
      y3_13    <= SB'(rnd_s(64'(y3p12), FR));
      y4_13    <= SB'(rnd_s(64'(y4p12), FR));
      a2_d[13] <= SB'(rnd_s(64'(a2p12), FR));
      a2_d[14] <= a2_d[13];
      a2_d[15] <= a2_d[14];
      a3p14 <= y3_13 * C03;
      a4p14 <= y4_13 * C01;
      a3_15 <= SB'(rnd_s(64'(a3p14), FR));
      a4_15 <= SB'(rnd_s(64'(a4p14), FR));

      // harmonic terms scaled by drive
      s23_16   <= (SB + 1)'(a2_d[15]) + (SB + 1)'(a3_15);
      b1p16    <= a4_15 * drv_s;
      h1p17    <= s23_16 * drv_s;
      b17      <= SB'(rnd_s(64'(b1p16), 15));
      h1_d[18] <= (SB + 1)'(rnd_s(64'(h1p17), 15));
      h1_d[19] <= h1_d[18];
      h2p18    <= b17 * drv_s;
      h2_19    <= SB'(rnd_s(64'(h2p18), 15));

      // post-gain, zero-drive bypass, cross-fade
      sum20  <= (SB + 2)'(y_d[19]) + (SB + 2)'(h1_d[19]) + (SB + 2)'(h2_19);
      wp21   <= sum20 * gain_post;
      wet22  <= drv_zero ? (SB + 2)'(flt_d[21]) : wet_shaped;
      mp1_23 <= dry_d[22] * mix_inv;
      mp2_23 <= wet22 * mix_s;
      tot24  <= (SB + 20)'(mp1_23) + (SB + 20)'(mp2_23);
    end
  end

  // output register with skid register behind it
  assign push = en && vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_sample <= skid_valid ? skid_sample : out_next;
    end else if (push) begin
      skid_sample <= out_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'(unsigned'(out_sample));

endmodule

@@ test/tb_asymmetric_saturation_mix.sv @@
// testbench for the asymmetric saturation mixer: stream stimulus, gain settings, output scoreboard
module tb_asymmetric_saturation_mix;
  import asat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // fixed-point constants of the shaper
  localparam int     F          = FRAC_BITS;
  localparam longint UNITY      = 32768;
  localparam longint PREGAIN_K  = 40;
  localparam longint POSTGAIN_K = 6554;
  localparam longint THRESH_04  = (longint'(1717986918) + (longint'(1) <<< (31 - F))) >>> (32 - F);
  localparam longint WEIGHT_03  = (longint'(1288490189) + (longint'(1) <<< (31 - F))) >>> (32 - F);
  localparam longint WEIGHT_01  = (longint'(429496730) + (longint'(1) <<< (31 - F))) >>> (32 - F);
  localparam longint SAMPLE_MAX = (longint'(1) <<< F) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< F);

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 125;
  localparam int MAX_PRINTS    = 40;

  typedef enum int {REG_DRIVE = 0, REG_MIX = 1} reg_index_e;
  typedef enum int {RES_OK, RES_WRONG, RES_ORPHAN} verdict_e;

  // gain registers, exp table and the queue of expected output samples
  class mix_scoreboard;
    longint      exp_q30[EXP_TABLE_DEPTH + 1];
    logic [15:0] drive_reg;
    logic [15:0] mix_reg;
    logic [SAMPLE_BITS-1:0] expected_q[$];
    int unsigned samples_in;
    int unsigned samples_out;

    function new();
      longint step;
      longint term;
      longint ratio;
      step  = (longint'(16) <<< 30) / EXP_TABLE_DEPTH;
      term  = longint'(1) <<< 30;
      ratio = longint'(1) <<< 30;
      // ratio between neighbouring entries from a series up to the 12th-order term
      for (int n = 1; n <= 12; n++) begin
        term = ((term * step) >>> 30) / n;
        if (n % 2 == 1) begin
          ratio -= term;
        end else begin
          ratio += term;
        end
      end
      exp_q30[0] = longint'(1) <<< 30;
      for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
        exp_q30[i] = round_shift(exp_q30[i - 1] * ratio, 30);
      end
      drive_reg   = '0;
      mix_reg     = '0;
      samples_in  = 0;
      samples_out = 0;
    endfunction

    // shift right, rounding half away from zero
    static function longint round_shift(longint v, int n);
      longint half;
      half = longint'(1) <<< (n - 1);
      if (v >= 0) begin
        return (v + half) >>> n;
      end
      return -((-v + half) >>> n);
    endfunction

    // exp(-arg) in Q30, linear between table entries, zero from 16 on
    function longint exp_lookup(longint arg);
      longint pos;
      longint idx;
      longint frac;
      if (arg >= (longint'(16) <<< F)) begin
        return 0;
      end
      pos  = arg * EXP_TABLE_DEPTH;
      idx  = pos >>> (F + 4);
      frac = (pos & ((longint'(1) <<< (F + 4)) - 1)) >>> (F + 4 - 16);
      if (idx >= EXP_TABLE_DEPTH) begin
        return exp_q30[EXP_TABLE_DEPTH];
      end
      return exp_q30[idx] - (((exp_q30[idx] - exp_q30[idx + 1]) * frac) >>> 16);
    endfunction

    // pre-gain, asymmetric knee, harmonics and post-gain
    function longint shape_wet(longint s, longint d);
      longint g, x, a, arg, mag, y2, y3, y4, h, p;
      g = UNITY + round_shift(PREGAIN_K * d * d, 15);
      x = round_shift(s * g, 15);
      a = (x < 0) ? -x : x;
      if (a > THRESH_04) begin
        // knee is steeper on the positive side
        arg = (a - THRESH_04) * ((x > 0) ? 4 : 2);
        mag = THRESH_04 + round_shift(THRESH_04 * ((longint'(1) <<< 30) - exp_lookup(arg)), 30);
        x = (x > 0) ? mag : -mag;
      end
      y2 = round_shift(x * x, F);
      y3 = round_shift(y2 * x, F);
      y4 = round_shift(y2 * y2, F);
      h = round_shift((round_shift(y2 * THRESH_04, F) + round_shift(y3 * WEIGHT_03, F)) * d, 15);
      h += round_shift(round_shift(round_shift(y4 * WEIGHT_01, F) * d, 15) * d, 15);
      p = UNITY - round_shift(d * POSTGAIN_K, 15);
      return round_shift((x + h) * p, 15);
    endfunction

    function logic [SAMPLE_BITS-1:0] mixed_sample(logic [SAMPLE_BITS-1:0] dry,
                                                  logic [SAMPLE_BITS-1:0] filt);
      longint dry_v, s, d, m, wet, y;
      dry_v = longint'($signed(dry));
      s     = longint'($signed(filt));
      // register values above unity count as unity
      d = (drive_reg > UNITY) ? UNITY : longint'(drive_reg);
      m = (mix_reg > UNITY) ? UNITY : longint'(mix_reg);
      wet = (d == 0) ? s : shape_wet(s, d);
      y = round_shift(dry_v * (UNITY - m) + wet * m, 15);
      if (y > SAMPLE_MAX) y = SAMPLE_MAX;
      if (y < SAMPLE_MIN) y = SAMPLE_MIN;
      return y[SAMPLE_BITS-1:0];
    endfunction

    function void set_register(reg_index_e idx, logic [15:0] value);
      if (idx == REG_DRIVE) begin
        drive_reg = value;
      end else begin
        mix_reg = value;
      end
    endfunction

    function void note_input(logic [SAMPLE_BITS-1:0] dry, logic [SAMPLE_BITS-1:0] filt);
      expected_q.push_back(mixed_sample(dry, filt));
      samples_in++;
    endfunction

    function verdict_e check_result(logic [SAMPLE_BITS-1:0] got,
                                    output logic [SAMPLE_BITS-1:0] want);
      want = '0;
      if (expected_q.size() == 0) begin
        return RES_ORPHAN;
      end
      want = expected_q.pop_front();
      samples_out++;
      return (got === want) ? RES_OK : RES_WRONG;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // dry_sample, filtered_sample
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // out_sample
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr    = '0;
  logic [CFG_DATA_W-1:0]  pwdata   = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  mix_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned settings    = 0;
  int          burst_left  = 0;
  logic [SAMPLE_BITS-1:0] want_out;

  asymmetric_saturation_mix dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // cycle count and run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    end
  endtask

  // receiver stall pattern, stepping through four styles as the cycle count grows
  always @(negedge clk) begin
    case ((cycle_count / 256) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 99) < 55);
      2:       m_tready <= (cycle_count % 7 == 0);
      default: m_tready <= ($urandom_range(0, 19) == 0) ? ~m_tready : m_tready;
    endcase
  end

  // accepted input items feed the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      sb.note_input(s_tdata[SAMPLE_BITS-1:0], s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    end
  end

  // accepted output items against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      case (sb.check_result(m_tdata[SAMPLE_BITS-1:0], want_out))
        RES_WRONG:  report_mismatch("out_sample", 32'(m_tdata[SAMPLE_BITS-1:0]), 32'(want_out));
        RES_ORPHAN: report_mismatch("unexpected item", 32'(m_tdata[SAMPLE_BITS-1:0]), 32'(0));
        default: ;
      endcase
    end
  end

  task automatic write_reg(input reg_index_e idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_ADDR_W'(4 * idx);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value[15:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    settings++;
  endtask

  task automatic read_check(input reg_index_e idx);
    logic [31:0] want;
    want    = {16'h0, (idx == REG_DRIVE) ? sb.drive_reg : sb.mix_reg};
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CFG_ADDR_W'(4 * idx);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      report_mismatch((idx == REG_DRIVE) ? "drive_amount read" : "mix_amount read", prdata, want);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // program both gains and read them back
  task automatic set_gains(input logic [31:0] drive, input logic [31:0] mix);
    write_reg(REG_DRIVE, drive);
    write_reg(REG_MIX, mix);
    read_check(REG_DRIVE);
    read_check(REG_MIX);
  endtask

  // hold the sender until every expected sample has come out
  task automatic drain_outputs();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one item in bursts with random gaps; called at a falling edge
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] dry,
                             input logic [SAMPLE_BITS-1:0] filt);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = 17;
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 30);
    end
    s_tdata  = {filt, dry};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    longint v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = SAMPLE_MAX;
          1:       v = SAMPLE_MIN;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      1, 2: v = longint'($urandom_range(0, 65535)) - 32768;
      3: begin
        // near the knee at unity gain, either side
        v = THRESH_04 + longint'($urandom_range(0, 2047)) - 1024;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = longint'($urandom());
    endcase
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [31:0] upper;
    upper = {16'($urandom_range(0, 65535)), 16'h0};
    case ($urandom_range(0, 5))
      0:       return upper | 32'd0;
      1:       return upper | 32'd32768;
      2:       return upper | 32'hFFFF;
      3:       return upper | $urandom_range(1, 16);
      4:       return upper | $urandom_range(32769, 65535);
      default: return upper | $urandom_range(0, 32768);
    endcase
  endfunction

  localparam logic [SAMPLE_BITS-1:0] S_MAX  = SAMPLE_MAX[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS-1:0] S_MIN  = SAMPLE_MIN[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS-1:0] S_KNEE = THRESH_04[SAMPLE_BITS-1:0];

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset gains: dry passes straight through
    read_check(REG_DRIVE);
    read_check(REG_MIX);
    send_sample('0, '0);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample('1, 24'd1);

    // zero drive, fully wet: output is the filtered sample
    drain_outputs();
    set_gains(32'd0, 32'd32768);
    send_sample(S_MAX, S_MAX);
    send_sample('0, S_MIN);
    send_sample(24'd1234, '1);

    // full drive: knee on both sides, exp past the table end, zero and tiny inputs
    drain_outputs();
    set_gains(32'd32768, 32'd32768);
    send_sample(S_MIN, S_MAX);
    send_sample(S_MAX, S_MIN);
    send_sample('0, S_KNEE / 41);
    send_sample('0, -(S_KNEE / 41));
    send_sample('0, S_KNEE);
    send_sample('0, -S_KNEE);
    send_sample(S_MAX, '0);
    send_sample(S_MIN, 24'd1);

    // registers above unity saturate
    drain_outputs();
    set_gains(32'hFFFF_FFFF, 32'h0000_FFFF);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample('0, S_KNEE / 41 + 24'd1);
    send_sample('0, -(S_KNEE / 41) - 24'd1);

    // smallest drive, half mix
    drain_outputs();
    set_gains(32'd1, 32'd16384);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(S_MAX, S_MIN);

    // random phases, each with its own gain setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_outputs();
      case (ph)
        0:       set_gains(32'd32768, 32'd0);
        1:       set_gains(32'd32768, 32'd32768);
        2:       set_gains(32'd0, 32'd32768);
        3:       set_gains(32'hFFFF, 32'hFFFF);
        default: set_gains(pick_gain(), pick_gain());
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == PHASE_ITEMS / 2) begin
          drain_outputs();
        end
        send_sample(pick_sample(), pick_sample());
      end
    end

    // let the pipeline empty, then settle
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      report_mismatch("samples never produced", sb.pending(), 0);
    end
    $display("run covered %0d samples through %0d register writes, %0d outputs checked",
             sb.samples_in, settings, sb.samples_out);
    $display("drive and mix went through zero, unity, above unity and random values");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
